[rtl/core/spq_pkg.sv]
// types and constants shared by the stable priority queue cells and top level
// no dependencies
package spq_pkg;

  localparam int unsigned PriW = 2;
  localparam int unsigned IdW  = 16;
  localparam int unsigned OccW = 5;

  typedef logic [PriW-1:0] pri_t;
  typedef logic [IdW-1:0]  id_t;

  // one held entry
  typedef struct packed {
    pri_t pri;
    id_t  id;
  } entry_t;

  // request kinds
  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_PUSHED = 2'd0,
    ST_FULL   = 2'd1,
    ST_SERVED = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // broadcast to every cell in the chain
  typedef struct packed {
    logic   insert;
    logic   remove;
    entry_t ins_entry;
  } cell_ctl_t;

endpackage

[rtl/core/stable_priority_queue.sv]
// stable four-level priority queue built as a chain of sorted cells
// depends on spq_pkg and spq_cell
//
// usage:
//   slave channel carries one request per item: s_tuser is the request kind
//   (push or pop), s_tdata holds priority and id of a push
//   master channel returns exactly one status item per request: m_tuser
//   status (pushed, full, served, empty), m_tdata id and priority of a
//   served entry plus the occupancy after the request
// structure:
//   DEPTH cells kept sorted by priority, ties in arrival order; a push is
//   broadcast to all cells, each compares its own priority and either keeps,
//   takes the new entry or takes its left neighbor's entry; a pop shifts all
//   cells one place toward the front
// timing:
//   one request per cycle while the output is not stalled, result registered; the
//   cell update and the status register are written at the same edge
// reset:
//   the entry count clears to zero and the output register empties; cell
//   contents are left as they are and only slots below the count are used
// stall:
//   while a result waits on m_tready, s_tready drops; no request is lost
module stable_priority_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // priority_req[1:0], entry_id[17:2], zero pad
  input  logic [0:0]  s_tuser,   // req_type[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // served_id[15:0], served_priority[17:16],
                                 // occupancy[22:18], zero pad
  output logic [1:0]  m_tuser    // status[1:0]
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // entry count
  logic [CntW-1:0] count;
  logic [CntW-1:0] count_next;

  // result register
  status_t         res_status;
  entry_t          res_entry;
  logic [OccW-1:0] res_occ;
  status_t         res_status_next;
  entry_t          res_entry_next;

  logic            accept;
  req_t            req;
  entry_t          in_entry;
  logic            full;
  logic            empty;
  cell_ctl_t       ctl;

  entry_t          cell_entry [DEPTH];
  logic [DEPTH-1:0] cell_disp;
  logic [DEPTH-1:0] cell_occ;
  logic [CntW+OccW-1:0] count_ext;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign req      = req_t'(s_tuser[0]);
  assign in_entry.pri = s_tdata[1:0];
  assign in_entry.id  = s_tdata[17:2];

  assign full  = (count == CntW'(DEPTH));
  assign empty = (count == '0);

  assign ctl.insert    = accept && (req == REQ_PUSH) && !full;
  assign ctl.remove    = accept && (req == REQ_POP) && !empty;
  assign ctl.ins_entry = in_entry;

  // the cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t le;
    entry_t re;
    logic   ld;

    assign cell_occ[i] = (count > CntW'(i));

    if (i == 0) begin : g_head
      assign le = in_entry;
      assign ld = 1'b0;
    end else begin : g_body
      assign le = cell_entry[i-1];
      assign ld = cell_disp[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign re = cell_entry[i];
    end else begin : g_mid
      assign re = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk            (clk),
      .ctl            (ctl),
      .occupied       (cell_occ[i]),
      .left_entry     (le),
      .left_displaced (ld),
      .right_entry    (re),
      .entry          (cell_entry[i]),
      .displaced      (cell_disp[i])
    );
  end

  // status and count for the accepted request
  always_comb begin
    count_next      = count;
    res_status_next = ST_PUSHED;
    res_entry_next  = '0;
    unique case (req)
      REQ_PUSH: begin
        if (full) begin
          res_status_next = ST_FULL;
        end else begin
          count_next = count + CntW'(1);
        end
      end
      REQ_POP: begin
        if (empty) begin
          res_status_next = ST_EMPTY;
        end else begin
          res_status_next = ST_SERVED;
          res_entry_next  = cell_entry[0];
          count_next      = count - CntW'(1);
        end
      end
      default: res_status_next = ST_PUSHED;
    endcase
  end

  // occupancy is reported modulo 32
  assign count_ext = {{OccW{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_status <= res_status_next;
      res_entry  <= res_entry_next;
      res_occ    <= count_ext[OccW-1:0];
    end
  end

  assign m_tuser = res_status;
  assign m_tdata = {1'b0, res_occ, res_entry.pri, res_entry.id};

endmodule

[rtl/core/spq_cell.sv]
// one slot of the sorted chain: keeps, takes the new entry, or shifts
// depends on spq_pkg
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  logic               occupied,
  input  spq_pkg::entry_t    left_entry,
  input  logic               left_displaced,
  input  spq_pkg::entry_t    right_entry,
  output spq_pkg::entry_t    entry,
  output logic               displaced
);
  import spq_pkg::*;

  entry_t entry_next;

  // slot sits behind the insertion point
  assign displaced = !occupied || (entry.pri > ctl.ins_entry.pri);

  always_comb begin
    entry_next = entry;
    if (ctl.insert) begin
      if (left_displaced) begin
        entry_next = left_entry;
      end else if (displaced) begin
        entry_next = ctl.ins_entry;
      end
    end else if (ctl.remove) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
